>>> rtl/core/swps_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package swps_pkg;

    localparam int WINDOW_DEPTH_DEF = 1024;
    localparam int SAMPLE_BITS_DEF  = 32;
    localparam int CFG_W            = 11;
    localparam int SPREAD_W         = 32;

    // commands from the sequencer to each monotonic queue
    typedef struct packed {
        logic start;   // a sample was taken: expire, pop, push
        logic finish;  // both queues are done: go back to idle
        logic clear;   // empty the queue
    } queue_ctrl_t;

endpackage

`default_nettype wire

>>> rtl/core/swps_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module swps_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_a_addr,
    output logic      [WIDTH-1:0]         rd_a_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_b_addr,
    output logic      [WIDTH-1:0]         rd_b_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_a_data <= mem[rd_a_addr];
        rd_b_data <= mem[rd_b_addr];
    end

endmodule

`default_nettype wire

>>> rtl/core/swps_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module swps_queue import swps_pkg::*; #(
    parameter int WINDOW_DEPTH = WINDOW_DEPTH_DEF,
    parameter int SAMPLE_BITS  = SAMPLE_BITS_DEF,
    parameter bit KEEP_MIN     = 1'b1
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire queue_ctrl_t                         ctrl,
    input  wire logic signed [SAMPLE_BITS-1:0]       sample,
    input  wire logic [$clog2(WINDOW_DEPTH):0]       position,
    input  wire logic [$clog2(WINDOW_DEPTH):0]       window,
    output logic                                     done,
    output logic signed [SAMPLE_BITS-1:0]            head_key
);

    localparam int AW       = $clog2(WINDOW_DEPTH);
    localparam int PW       = AW + 1;
    localparam int RAM_D    = 1 << AW;
    localparam int ENTRY_W  = SAMPLE_BITS + PW;

    typedef enum logic [1:0] {Q_IDLE, Q_EXPIRE, Q_POP, Q_DONE} q_state_t;

    q_state_t               state_reg, state_next;
    logic [AW-1:0]          head_reg, head_next, head1;
    logic [PW-1:0]          count_reg, count_next, cnt1;
    logic signed [SAMPLE_BITS-1:0] head_key_reg;
    logic [PW-1:0]          head_pos_reg;

    logic                   busy, expire, drop, push;
    logic [PW-1:0]          age;
    logic signed [SAMPLE_BITS-1:0] back_key, next_head_key;
    logic [PW-1:0]          next_head_pos;
    logic [ENTRY_W-1:0]     rd_a_data, rd_b_data;
    logic [AW-1:0]          rd_a_addr, rd_b_addr, wr_addr;

    assign busy          = (state_reg == Q_EXPIRE) || (state_reg == Q_POP);
    assign age           = position - head_pos_reg;
    assign expire        = (state_reg == Q_EXPIRE) && (count_reg != '0) && (age >= window);
    assign cnt1          = count_reg - PW'(expire);
    assign head1         = head_reg + AW'(expire);
    assign back_key      = $signed(rd_b_data[ENTRY_W-1:PW]);
    assign next_head_key = $signed(rd_a_data[ENTRY_W-1:PW]);
    assign next_head_pos = rd_a_data[PW-1:0];

    always_comb
    begin
        drop = 1'b0;
        if (busy && (cnt1 != '0))
        begin
            if (KEEP_MIN)
            begin
                drop = (back_key >= sample);
            end
            else
            begin
                drop = (back_key <= sample);
            end
        end
    end

    assign push    = busy && !drop;
    assign wr_addr = head1 + cnt1[AW-1:0];

    always_comb
    begin
        state_next = state_reg;
        head_next  = head_reg;
        count_next = count_reg;
        case (state_reg)
            Q_IDLE:
            begin
                if (ctrl.start)
                begin
                    state_next = Q_EXPIRE;
                end
            end
            Q_EXPIRE, Q_POP:
            begin
                head_next = head1;
                if (drop)
                begin
                    count_next = cnt1 - PW'(1);
                    state_next = Q_POP;
                end
                else
                begin
                    count_next = cnt1 + PW'(1);
                    state_next = Q_DONE;
                end
            end
            Q_DONE:
            begin
                if (ctrl.finish)
                begin
                    state_next = Q_IDLE;
                end
            end
            default:
            begin
                state_next = Q_IDLE;
            end
        endcase
        if (ctrl.clear)
        begin
            head_next  = '0;
            count_next = '0;
        end
    end

    // fetch the entry after the head and the current back for the next step
    assign rd_a_addr = head_next + AW'(1);
    assign rd_b_addr = head_next + count_next[AW-1:0] - AW'(1);

    swps_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (RAM_D)
    ) u_ram (
        .clk       (clk),
        .wr_en     (push),
        .wr_addr   (wr_addr),
        .wr_data   ({sample, position}),
        .rd_a_addr (rd_a_addr),
        .rd_a_data (rd_a_data),
        .rd_b_addr (rd_b_addr),
        .rd_b_data (rd_b_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= Q_IDLE;
            head_reg     <= '0;
            count_reg    <= '0;
            head_key_reg <= '0;
            head_pos_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            head_reg  <= head_next;
            count_reg <= count_next;
            // head entry cache: advance on expire, take the new sample if the queue ran empty
            if (push && (cnt1 == '0))
            begin
                head_key_reg <= sample;
                head_pos_reg <= position;
            end
            else if (expire)
            begin
                head_key_reg <= next_head_key;
                head_pos_reg <= next_head_pos;
            end
        end
    end

    assign done     = (state_reg == Q_DONE);
    assign head_key = head_key_reg;

endmodule

`default_nettype wire

>>> rtl/core/sliding_window_peak_spread.sv
`timescale 1ns / 1ps
`default_nettype none

// Flow: a taken sample passes through the expire and pop steps of both queues and then the
//   finish state; a final sample's result waits while the previous result is still held by the receiver.
// Samples: a new sample is taken only once the previous one is through, and each entry
//   popped from the back of the min or max queue for a sample costs one RAM read.
// Reset: asynchronous, active low; empties both queues, clears counts and the best
//   spread, and sets the window length to 1. Queue RAM contents need no clearing.
module sliding_window_peak_spread import swps_pkg::*; #(
    parameter int WINDOW_DEPTH = WINDOW_DEPTH_DEF,
    parameter int SAMPLE_BITS  = SAMPLE_BITS_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [CFG_W-1:0]              window_length,
    input  wire logic                          item_valid,
    output logic                               item_stall,
    input  wire logic signed [SAMPLE_BITS-1:0] sample,
    input  wire logic                          last,
    output logic                               result_valid,
    input  wire logic                          result_stall,
    output logic [SPREAD_W-1:0]                max_spread
);

    localparam int AW    = $clog2(WINDOW_DEPTH);
    localparam int PW    = AW + 1;
    localparam int EXT_W = (SAMPLE_BITS > SPREAD_W) ? SAMPLE_BITS : SPREAD_W;
    localparam logic [PW-1:0] DEPTH_P = PW'(WINDOW_DEPTH);

    typedef enum logic [1:0] {S_IDLE, S_QUEUE, S_FINISH} state_t;

    state_t                        state_reg;
    logic [PW-1:0]                 window_reg;
    logic [PW-1:0]                 position_reg;
    logic [PW-1:0]                 seen_reg;
    logic [SAMPLE_BITS-1:0]        best_reg, best_next;
    logic [SAMPLE_BITS-1:0]        spread_reg;
    logic signed [SAMPLE_BITS-1:0] sample_reg;
    logic                          last_reg;
    logic                          result_valid_reg;
    logic [SPREAD_W-1:0]           max_spread_reg;

    queue_ctrl_t                   ctrl;
    logic                          accept, cfg_fire, both_done, out_free, restart;
    logic                          min_done, max_done;
    logic signed [SAMPLE_BITS-1:0] min_key, max_key;
    logic signed [SAMPLE_BITS:0]   diff;
    logic [31:0]                   cfg_wide, win_sat;
    logic [EXT_W-1:0]              best_ext;

    // hold the input while a sample is in progress or a register write is offered
    assign item_stall = (state_reg != S_IDLE) || cfg_valid;
    assign cfg_ready  = (state_reg == S_IDLE);
    assign accept     = item_valid && !item_stall;
    assign cfg_fire   = cfg_valid && cfg_ready;
    assign both_done  = min_done && max_done;
    assign out_free   = !result_valid_reg || !result_stall;
    assign restart    = (state_reg == S_FINISH) && last_reg && out_free;

    assign ctrl.start  = accept;
    assign ctrl.finish = (state_reg == S_QUEUE) && both_done;
    assign ctrl.clear  = cfg_fire || restart;

    // zero means one, and the length is capped at the queue depth
    always_comb
    begin
        cfg_wide = 32'(window_length);
        if (cfg_wide == 32'd0)
        begin
            win_sat = 32'd1;
        end
        else if (cfg_wide > 32'(WINDOW_DEPTH))
        begin
            win_sat = 32'(WINDOW_DEPTH);
        end
        else
        begin
            win_sat = cfg_wide;
        end
    end

    assign diff = $signed({max_key[SAMPLE_BITS-1], max_key})
                - $signed({min_key[SAMPLE_BITS-1], min_key});

    always_comb
    begin
        best_next = best_reg;
        if ((seen_reg >= window_reg) && (spread_reg > best_reg))
        begin
            best_next = spread_reg;
        end
    end

    assign best_ext = EXT_W'(best_next);

    swps_queue #(
        .WINDOW_DEPTH (WINDOW_DEPTH),
        .SAMPLE_BITS  (SAMPLE_BITS),
        .KEEP_MIN     (1'b1)
    ) u_min_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (ctrl),
        .sample   (sample_reg),
        .position (position_reg),
        .window   (window_reg),
        .done     (min_done),
        .head_key (min_key)
    );

    swps_queue #(
        .WINDOW_DEPTH (WINDOW_DEPTH),
        .SAMPLE_BITS  (SAMPLE_BITS),
        .KEEP_MIN     (1'b0)
    ) u_max_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (ctrl),
        .sample   (sample_reg),
        .position (position_reg),
        .window   (window_reg),
        .done     (max_done),
        .head_key (max_key)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            window_reg       <= PW'(1);
            position_reg     <= '0;
            seen_reg         <= '0;
            best_reg         <= '0;
            result_valid_reg <= 1'b0;
            max_spread_reg   <= '0;
        end
        else
        begin
            if (restart)
            begin
                result_valid_reg <= 1'b1;
                max_spread_reg   <= best_ext[SPREAD_W-1:0];
            end
            else if (!result_stall)
            begin
                result_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (cfg_fire)
                    begin
                        window_reg   <= win_sat[PW-1:0];
                        position_reg <= '0;
                        seen_reg     <= '0;
                        best_reg     <= '0;
                    end
                    else if (accept)
                    begin
                        state_reg <= S_QUEUE;
                    end
                end
                S_QUEUE:
                begin
                    if (both_done)
                    begin
                        position_reg <= position_reg + PW'(1);
                        if (seen_reg < DEPTH_P)
                        begin
                            seen_reg <= seen_reg + PW'(1);
                        end
                        state_reg <= S_FINISH;
                    end
                end
                S_FINISH:
                begin
                    if (!last_reg)
                    begin
                        best_reg  <= best_next;
                        state_reg <= S_IDLE;
                    end
                    else if (out_free)
                    begin
                        position_reg <= '0;
                        seen_reg     <= '0;
                        best_reg     <= '0;
                        state_reg    <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            sample_reg <= sample;
            last_reg   <= last;
        end
        if ((state_reg == S_QUEUE) && both_done)
        begin
            spread_reg <= diff[SAMPLE_BITS-1:0];
        end
    end

    assign result_valid = result_valid_reg;
    assign max_spread   = max_spread_reg;

endmodule

`default_nettype wire
